// ===== hdl/tsg_pkg.sv =====
// Package for the tone sample generator: sizes, register map, stage types
// and the quarter-wave sine table built at elaboration.
// No dependencies.
package tsg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 8;
  localparam int ROM_IDX_W      = SINE_ADDR_BITS + 1;
  localparam int SINE_ENTRIES   = (1 << SINE_ADDR_BITS) + 1;

  // APB register map, word addressed
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_WAVE_SHAPE = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_BYTES      = 2'd2;

  localparam logic WAVE_SQUARE = 1'b0;
  localparam logic WAVE_SINE   = 1'b1;

  // sample width codes: bytes per sample minus one
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_24 = 2'd2;
  localparam logic [1:0] WIDTH_32 = 2'd3;

  localparam logic [63:0] PIH_Q31 = 64'd3373259426;  // pi/2 in Q1.31
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  typedef logic [31:0] sine_rom_t [SINE_ENTRIES];

  // control carried alongside the table read
  typedef struct packed {
    logic       sine;
    logic       neg;
    logic [1:0] width;
    logic       fin;
  } s1_ctrl_t;

  // Unsigned 64-bit quotient, restoring long division (table build only).
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncated Taylor series of sin(pi/2 * j / 2^A), Q1.31, clamped to 0..1.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        n;
    logic signed [63:0] sum;
    logic               minus;
    for (int j = 0; j < SINE_ENTRIES; j++) begin
      x     = (PIH_Q31 * 64'(j)) >> SINE_ADDR_BITS;
      x2    = (x * x) >> 31;
      term  = x;
      sum   = $signed(x);
      n     = 64'd1;
      minus = 1'b1;
      for (int s = 0; s < 30; s++) begin
        if (term != 64'd0) begin
          term = udiv64((term * x2) >> 31, (n + 64'd1) * (n + 64'd2));
          n    = n + 64'd2;
          if (minus) begin
            sum = sum - $signed(term);
          end else begin
            sum = sum + $signed(term);
          end
          minus = !minus;
        end
      end
      if (sum < 64'sd0) begin
        sum = 64'sd0;
      end
      if (sum > 64'sd2147483648) begin
        sum = 64'sd2147483648;
      end
      rom[j] = sum[31:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== hdl/tone_sample_generator_top.sv =====
// Tone sample generator top level: phase accumulator, registered sine
// table, quantizer and byte serializer. Depends on tsg_pkg.
module tone_sample_generator_top
  import tsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // sample request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  input  logic                  final_sample_i,
  // byte channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            sample_byte_o,
  output logic                  last_byte_o,
  output logic                  buffer_end_o
);
  // Usage
  // - Program wave_shape (0x0), phase_step (0x4) and the sample width in
  //   bytes (0x8) over APB while the block is idle; reset gives square,
  //   step 0, 16 bit.
  // - Each transfer on the request channel yields one PCM sample sent as
  //   1..4 byte transfers, low byte first, last_byte set on the final one
  //   and buffer_end copying final_sample on all of them.
  // - restart clears the phase before this sample is formed; the phase then
  //   advances by phase_step after every sample.
  // - The request passes the table read, quantize and serializer load
  //   registers in turn before out_valid rises, and the first byte
  //   transfers once the receiver is ready.
  // - Throughput: one byte per cycle on the output while the receiver is
  //   ready; the serializer register sets this, one transfer per byte (1..4).
  //   Requests are taken while earlier samples drain, until both stages fill.
  // - When the receiver stalls, the byte holds and the two pipeline stages
  //   fill; request ready then drops until the serializer frees up.
  // - Reset clears the phase and all valid flags and sets the default config.

  // ---------------------------------------------------------------- config
  logic                  wave_shape_q;
  logic [31:0]           phase_step_q;
  logic [2:0]            bytes_q;
  logic                  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q <= WAVE_SQUARE;
      phase_step_q <= '0;
      bytes_q      <= 3'd2;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WAVE_SHAPE: wave_shape_q <= pwdata[0];
        REG_PHASE_STEP: phase_step_q <= pwdata;
        REG_BYTES:      bytes_q      <= pwdata[2:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WAVE_SHAPE: prdata = {31'd0, wave_shape_q};
      REG_PHASE_STEP: prdata = phase_step_q;
      REG_BYTES:      prdata = {29'd0, bytes_q};
      default:        prdata = '0;
    endcase
  end

  // ------------------------------------------------------ pipeline control
  logic in_fire;
  logic out_fire;
  logic s1_valid_q;
  logic s2_valid_q;
  logic ser_valid_q;
  logic [1:0] rem_q;
  logic ser_last;
  logic ser_load;
  logic s2_free;
  logic s1_adv;

  assign ser_last   = (rem_q == 2'd0);
  assign out_fire   = out_valid_o & out_ready_i;
  assign ser_load   = s2_valid_q & (!ser_valid_q | (out_fire & ser_last));
  assign s2_free    = !s2_valid_q | ser_load;
  assign s1_adv     = s1_valid_q & s2_free;
  assign in_ready_o = !s1_valid_q | s2_free;
  assign in_fire    = in_valid_i & in_ready_o;

  // ------------------------------------------------ phase and table address
  logic [PHASE_BITS-1:0]     phase_q;
  logic [PHASE_BITS-1:0]     phase_cur;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] k_idx;
  logic [ROM_IDX_W-1:0]      rom_addr;
  logic [1:0]                width_code;

  assign phase_cur = restart_i ? '0 : phase_q;
  assign quad      = phase_cur[PHASE_BITS-1 -: 2];
  assign k_idx     = phase_cur[PHASE_BITS-3 -: SINE_ADDR_BITS];
  // odd quadrants run the table backwards
  assign rom_addr  = quad[0] ? ({1'b1, {SINE_ADDR_BITS{1'b0}}} - {1'b0, k_idx})
                             : {1'b0, k_idx};

  always_comb begin
    case (bytes_q)
      3'd0, 3'd1: width_code = WIDTH_8;
      3'd2:       width_code = WIDTH_16;
      3'd3:       width_code = WIDTH_24;
      default:    width_code = WIDTH_32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_cur + PHASE_BITS'(phase_step_q);
    end
  end

  // ------------------------------------------------- stage 1: table read
  logic [31:0] rom_q;
  s1_ctrl_t    s1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rom_q      <= SINE_ROM[rom_addr];
      s1_q.sine  <= wave_shape_q;
      s1_q.neg   <= (wave_shape_q == WAVE_SINE) ? quad[1] : phase_cur[PHASE_BITS-1];
      s1_q.width <= width_code;
      s1_q.fin   <= final_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------- stage 2: quantize
  logic [31:0] mag;
  logic [32:0] biased;
  logic [40:0] scaled8;
  logic [62:0] shifted;
  logic [62:0] scaled;
  logic [31:0] v_abs;
  logic [31:0] word_d;
  logic [31:0] word_q;
  logic [1:0]  s2_width_q;
  logic        s2_fin_q;

  assign mag = s1_q.sine ? rom_q : ONE_Q31;

  always_comb begin
    // 8 bit: floor(255 * (a + 1) / 2), as (u << 8) - u
    biased  = s1_q.neg ? ({1'b0, ONE_Q31} - {1'b0, mag}) : ({1'b0, ONE_Q31} + {1'b0, mag});
    scaled8 = ({8'd0, biased} << 8) - {8'd0, biased};
    // wider: |a| * (2^(bits-1) - 1) as shift and subtract
    case (s1_q.width)
      WIDTH_16: shifted = {31'd0, mag} << 15;
      WIDTH_24: shifted = {31'd0, mag} << 23;
      default:  shifted = {31'd0, mag} << 31;
    endcase
    scaled = shifted - {31'd0, mag};
    v_abs  = scaled[62:31];
    if (s1_q.width == WIDTH_8) begin
      word_d = {24'd0, scaled8[39:32]};
    end else if (s1_q.neg) begin
      word_d = 32'd0 - v_abs;
    end else begin
      word_d = v_abs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      word_q     <= word_d;
      s2_width_q <= s1_q.width;
      s2_fin_q   <= s1_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= 1'b1;
    end else if (ser_load) begin
      s2_valid_q <= 1'b0;
    end
  end

  // ------------------------------------------------- byte serializer
  logic [31:0] ser_word_q;
  logic        ser_fin_q;

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_word_q <= word_q;
      ser_fin_q  <= s2_fin_q;
    end else if (out_fire) begin
      ser_word_q <= ser_word_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      rem_q       <= '0;
    end else if (ser_load) begin
      ser_valid_q <= 1'b1;
      rem_q       <= s2_width_q;
    end else if (out_fire) begin
      if (ser_last) begin
        ser_valid_q <= 1'b0;
      end else begin
        rem_q <= rem_q - 2'd1;
      end
    end
  end

  assign out_valid_o   = ser_valid_q;
  assign sample_byte_o = ser_word_q[7:0];
  assign last_byte_o   = ser_last;
  assign buffer_end_o  = ser_fin_q;

  // ------------------------------------------------------- assertions
  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && restart_i |=> phase_q == PHASE_BITS'(phase_step_q))
    else $error("phase not restarted");

  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_byte_o |=> out_valid_o && rem_q == $past(rem_q) - 2'd1)
    else $error("sample bytes lost");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(rom_q))
    else $error("table stage overwritten while stalled");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !ser_load |=> s2_valid_q && $stable(word_q))
    else $error("quantized sample overwritten while stalled");

endmodule

// ===== bench/tone_sample_generator_top_test.sv =====
// Self-checking bench for the tone sample generator: walks a directed table, then random
// phases of config and sample requests, and checks every output byte.
// Depends on tsg_pkg and tone_sample_generator_top.
`timescale 1ns / 100ps

module tone_sample_generator_top_test;
  import tsg_pkg::*;

  localparam int ITEMS_TOTAL = 270;  // sample requests over the whole run
  localparam int CALM_ITEMS  = 40;   // tail of the run with no idling at all
  localparam int CYCLE_LIMIT = 300000;

  // widths the predictor works at
  localparam int TONE_PHASE_W = 32;
  localparam int SINE_IDX_W   = 8;
  localparam logic [63:0]        HALF_PI_Q31 = 64'd3373259426;
  localparam logic signed [63:0] UNITY_Q31   = 64'sd2147483648;

  localparam bit KNOWN = 1'b1;  // row carries its expected word
  localparam bit MODEL = 1'b0;  // row is checked against the predictor

  // one output byte as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       buf_end;
  } tone_byte_t;

  // one row of the directed table: config to hold, then one sample request
  typedef struct packed {
    logic        wave;
    logic [31:0] step;
    logic [2:0]  nbytes;
    logic        restart;
    logic        fin;
    bit          known;
    logic [31:0] word;
  } tone_row_t;

  localparam int DIR_ROWS = 25;

  // Phase bookkeeping is noted per row where the expected word is typed in.
  tone_row_t dir_rows [DIR_ROWS] = '{
    // reset config: square, step 0, 16 bit; phase 0 gives full scale
    '{WAVE_SQUARE, 32'h0000_0000, 3'd2, 1'b0, 1'b0, KNOWN, 32'h0000_7FFF},
    // half-period step flips the square every sample, 32 bit extremes
    '{WAVE_SQUARE, 32'h8000_0000, 3'd4, 1'b1, 1'b0, KNOWN, 32'h7FFF_FFFF},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd4, 1'b0, 1'b1, KNOWN, 32'h8000_0001},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd4, 1'b0, 1'b0, KNOWN, 32'h7FFF_FFFF},
    // 8 bit is unsigned: -1 -> 0x00, +1 -> 0xFF
    '{WAVE_SQUARE, 32'h8000_0000, 3'd1, 1'b0, 1'b0, KNOWN, 32'h0000_0000},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd1, 1'b0, 1'b1, KNOWN, 32'h0000_00FF},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd3, 1'b1, 1'b0, KNOWN, 32'h007F_FFFF},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd3, 1'b0, 1'b1, KNOWN, 32'h0080_0001},
    // byte count zero acts as one, five to seven act as four
    '{WAVE_SQUARE, 32'h8000_0000, 3'd0, 1'b1, 1'b0, KNOWN, 32'h0000_00FF},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd7, 1'b0, 1'b0, KNOWN, 32'h8000_0001},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd5, 1'b1, 1'b1, KNOWN, 32'h7FFF_FFFF},
    '{WAVE_SQUARE, 32'h8000_0000, 3'd6, 1'b0, 1'b0, KNOWN, 32'h8000_0001},
    // sine at phase 0 is zero; zero step repeats it
    '{WAVE_SINE,   32'h0000_0000, 3'd2, 1'b1, 1'b0, KNOWN, 32'h0000_0000},
    '{WAVE_SINE,   32'h0000_0000, 3'd2, 1'b0, 1'b1, KNOWN, 32'h0000_0000},
    '{WAVE_SINE,   32'h0000_0000, 3'd1, 1'b1, 1'b0, KNOWN, 32'h0000_007F},
    // quarter-period step visits each quadrant start
    '{WAVE_SINE,   32'h4000_0000, 3'd4, 1'b1, 1'b0, KNOWN, 32'h0000_0000},
    '{WAVE_SINE,   32'h4000_0000, 3'd4, 1'b0, 1'b0, MODEL, 32'h0},
    '{WAVE_SINE,   32'h4000_0000, 3'd4, 1'b0, 1'b1, KNOWN, 32'h0000_0000},
    '{WAVE_SINE,   32'h4000_0000, 3'd4, 1'b0, 1'b0, MODEL, 32'h0},
    // max step walks backward into the last quadrant
    '{WAVE_SINE,   32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, KNOWN, 32'h0000_0000},
    '{WAVE_SINE,   32'hFFFF_FFFF, 3'd3, 1'b0, 1'b0, MODEL, 32'h0},
    '{WAVE_SINE,   32'h0100_0000, 3'd2, 1'b0, 1'b1, MODEL, 32'h0},
    '{WAVE_SINE,   32'h1234_5679, 3'd1, 1'b0, 1'b0, MODEL, 32'h0},
    // square just below half period is still positive
    '{WAVE_SQUARE, 32'h7FFF_FFFF, 3'd2, 1'b1, 1'b1, KNOWN, 32'h0000_7FFF},
    '{WAVE_SQUARE, 32'h7FFF_FFFF, 3'd2, 1'b0, 1'b0, KNOWN, 32'h0000_7FFF}
  };

  // DUT ports; every input starts at a known value
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [31:0]           pwdata         = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i      = 1'b0;
  logic                  final_sample_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b1;
  logic [7:0]            sample_byte_o;
  logic                  last_byte_o;
  logic                  buffer_end_o;

  // predictor state: config shadow and phase accumulator
  logic                    cfg_wave   = WAVE_SQUARE;
  logic [31:0]             cfg_step   = '0;
  logic [2:0]              cfg_nbytes = 3'd2;
  logic [TONE_PHASE_W-1:0] phase_acc  = '0;

  tone_byte_t pending_bytes [$];  // bytes owed by accepted samples, oldest first
  int         mismatch_cnt   = 0;
  int         samples_sent   = 0;
  int         cycle_cnt      = 0;
  int         src_gap_pct    = 0;  // chance of a gap before each sample request
  int         sink_stall_pct = 0;  // per-cycle chance the byte sink starts a stall

  tone_sample_generator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .final_sample_i(final_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_byte_o (sample_byte_o),
    .last_byte_o   (last_byte_o),
    .buffer_end_o  (buffer_end_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Quarter-wave entry j: truncated Taylor series of sin(pi/2 * j / 2^A) in Q1.31,
  // clamped to 0..1.
  function automatic logic signed [63:0] quarter_sine_q31(int unsigned j);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        n;
    logic signed [63:0] sum;
    bit                 minus;
    x     = (HALF_PI_Q31 * 64'(j)) >> SINE_IDX_W;
    x2    = (x * x) >> 31;
    term  = x;
    sum   = $signed(x);
    n     = 64'd1;
    minus = 1'b1;
    while (term != 64'd0 && n < 64'd60) begin
      term = ((term * x2) >> 31) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if (minus) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
      minus = !minus;
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > UNITY_Q31) begin
      sum = UNITY_Q31;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] amplitude_q31(logic [TONE_PHASE_W-1:0] ph,
                                                       logic wave);
    logic [1:0]         quad;
    int unsigned        k;
    int unsigned        j;
    logic signed [63:0] t;
    if (wave == WAVE_SQUARE) begin
      return ph[TONE_PHASE_W-1] ? -UNITY_Q31 : UNITY_Q31;
    end
    quad = ph[TONE_PHASE_W-1 -: 2];
    k    = 32'(ph[TONE_PHASE_W-3 -: SINE_IDX_W]);
    j    = quad[0] ? (32'd1 << SINE_IDX_W) - k : k;
    t    = quarter_sine_q31(j);
    return quad[1] ? -t : t;
  endfunction

  // register value to bytes actually sent
  function automatic int byte_count(logic [2:0] nb);
    if (nb == 3'd0) begin
      return 1;
    end
    return (nb > 3'd4) ? 4 : int'(nb);
  endfunction

  // 8 bit: unsigned, floor(255 * (a + 1) / 2); wider: signed, truncated toward zero
  function automatic logic [31:0] quantize_sample(logic signed [63:0] a, int n);
    logic [63:0] u;
    logic [63:0] peak;
    logic [63:0] mag;
    logic [63:0] v;
    if (n == 1) begin
      u = a + UNITY_Q31;
      return 32'((u * 64'd255) >> 32);
    end
    peak = (64'd1 << (8 * n - 1)) - 64'd1;
    if (a < 0) begin
      mag = -a;
    end else begin
      mag = a;
    end
    v = (mag * peak) >> 31;
    if (a < 0) begin
      v = -v;
    end
    return v[31:0];
  endfunction

  // word for the next sample; advances the phase like the block does
  function automatic logic [31:0] next_tone_word(logic restart);
    logic [31:0] w;
    if (restart) begin
      phase_acc = '0;
    end
    w         = quantize_sample(amplitude_q31(phase_acc, cfg_wave), byte_count(cfg_nbytes));
    phase_acc = phase_acc + cfg_step;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup, then access; lands on the edge with penable and pready high,
  // then the bus goes idle so back-to-back writes start on a fresh edge
  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop requesting, let every owed byte come out, then idle before returning
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Config only changes with the block idle; registers that already hold the
  // wanted value are left alone.
  task automatic apply_config(logic wave, logic [31:0] step, logic [2:0] nb);
    if (wave != cfg_wave || step != cfg_step || nb != cfg_nbytes) begin
      wait_for_drain();
      if (wave != cfg_wave) begin
        apb_write(REG_WAVE_SHAPE, 32'(wave));
        cfg_wave = wave;
      end
      if (step != cfg_step) begin
        apb_write(REG_PHASE_STEP, step);
        cfg_step = step;
      end
      if (nb != cfg_nbytes) begin
        apb_write(REG_BYTES, 32'(nb));
        cfg_nbytes = nb;
      end
    end
  endtask

  // Drives a sample request transfer. Called just after the clock rises. The owed
  // bytes go on the queue at the accepting edge; a known word overrides the
  // predictor, which still runs so the phase stays in step.
  task automatic send_sample(logic restart, logic fin, bit known, logic [31:0] word);
    logic [31:0] w;
    int          n;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    restart_i      <= restart;
    final_sample_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    w = next_tone_word(restart);
    if (known) begin
      w = word;
    end
    n = byte_count(cfg_nbytes);
    for (int k = 0; k < n; k++) begin
      pending_bytes.push_back('{w[8*k +: 8], k == n - 1, fin});
    end
    samples_sent++;
  endtask

  // Byte sink: stalls in random bursts whenever the current level allows.
  initial begin
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each byte transfer against the oldest owed byte
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tone_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: byte %02h last %0b end %0b with no sample pending", $realtime,
                   sample_byte_o, last_byte_o, buffer_end_o);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (want != {sample_byte_o, last_byte_o, buffer_end_o}) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: expected byte %02h last %0b end %0b, got %02h last %0b end %0b",
                     $realtime, want.data, want.last, want.buf_end,
                     sample_byte_o, last_byte_o, buffer_end_o);
          end
        end
      end
    end
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          gap_levels [3];
    int          stall_levels [3];
    int          phase_len;
    bit          calm;
    logic [31:0] step;
    gap_levels   = '{0, 15, 45};
    stall_levels = '{0, 5, 25};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, light idling on both sides
    src_gap_pct    = 20;
    sink_stall_pct = 10;
    for (int i = 0; i < DIR_ROWS; i++) begin
      apply_config(dir_rows[i].wave, dir_rows[i].step, dir_rows[i].nbytes);
      send_sample(dir_rows[i].restart, dir_rows[i].fin, dir_rows[i].known, dir_rows[i].word);
    end

    // Random phases: fresh config each time, then a run of buffers. Restart
    // marks a new tone, final_sample closes a buffer. The tail runs flat out.
    while (samples_sent < ITEMS_TOTAL) begin
      calm = samples_sent >= ITEMS_TOTAL - CALM_ITEMS;
      case ($urandom_range(0, 5))
        0:       step = 32'h0000_0000;
        1:       step = 32'hFFFF_FFFF;
        2:       step = 32'h8000_0000;
        3:       step = $urandom_range(1, 32'h0100_0000);  // fine steps through the table
        default: step = $urandom;
      endcase
      apply_config(1'($urandom_range(0, 1)), step, 3'($urandom_range(0, 7)));
      if (calm) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        phase_len      = ITEMS_TOTAL - samples_sent;
      end else begin
        src_gap_pct    = gap_levels[$urandom_range(0, 2)];
        sink_stall_pct = stall_levels[$urandom_range(0, 2)];
        phase_len      = $urandom_range(8, 30);
      end
      repeat (phase_len) begin
        send_sample($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0, MODEL, 32'h0);
      end
    end

    wait_for_drain();
    repeat (12) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
